// ===== src/tlf_pkg.sv =====
// Shared constants and types for the text line folder.
package tlf_pkg;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BLANK = 8'd32;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_entry_t;

endpackage

// ===== src/text_line_folder_core.sv =====
// Text line folder top level: line buffer control, emit sequencer and channels.
//
//   channel | signals                         | dir | moves
//   --------+---------------------------------+-----+-------------------------------
//   in      | in_valid, in_stall, in_char     | in  | one character per transaction
//   out     | out_valid, out_stall, out_char, | out | one output character per
//           | last                            |     | transaction, last on final one
//
// An ordinary character that does not fill the line is written without stalling the input.
// A tab writes its blanks one at a time, the first when it is accepted, the rest in S_TAB.
// A line flush reads the line from memory, one read per character, then issues the
// newline; each character passes the RAM read register and the token register into
// the output queue before it reaches out; out_stall slows this.
// No clearing pass after reset; the line buffer is never read before it is written.
// in_stall is high while a tab expands or a line is being read out.
module text_line_folder_core #(
  parameter int LINE_WIDTH = 32,
  parameter int TAB_STOP   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int CW = $clog2(LINE_WIDTH + 1);
  localparam logic [CW-1:0] W_C = CW'(LINE_WIDTH);

  function automatic logic [LINE_WIDTH:0] stop_map();
    logic [LINE_WIDTH:0] m;
    int ph;
    m  = '0;
    ph = 0;
    for (int i = 0; i <= LINE_WIDTH; i++) begin
      m[i] = (ph == 0);
      ph   = ph + 1;
      if (ph == TAB_STOP) begin
        ph = 0;
      end
    end
    return m;
  endfunction

  localparam logic [LINE_WIDTH:0] STOP_MAP = stop_map();

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(off);
    if (s >= (CW+1)'(LINE_WIDTH)) begin
      s = s - (CW+1)'(LINE_WIDTH);
    end
    return s[AW-1:0];
  endfunction

  typedef enum logic [1:0] {S_IDLE, S_TAB, S_EMIT} state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [AW-1:0] base;
  logic [CW-1:0] last_blank;
  logic [CW-1:0] emit_idx;
  logic [CW-1:0] emit_len;
  logic [CW-1:0] emit_rest;
  logic          tok_valid;
  logic          tok_nl;

  logic          in_acc;
  logic          pop;
  logic [1:0]    fifo_cnt;
  logic [1:0]    occ;
  logic          can_issue;
  logic          issue;
  logic          issue_nl;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          char_blank;
  logic [CW-1:0] lbx;

  tlf_pkg::out_entry_t push_entry;
  tlf_pkg::out_entry_t head;

  assign in_stall   = (state != S_IDLE);
  assign in_acc     = in_valid & ~in_stall;
  assign pop        = out_valid & ~out_stall;
  assign occ        = fifo_cnt + 2'(tok_valid);
  assign can_issue  = (occ < 2'd2) | pop;
  assign char_blank = (in_char == tlf_pkg::CH_BLANK) && (fill != '0);
  assign lbx        = char_blank ? fill : last_blank;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = phys(base, fill);
    wr_data  = in_char;
    rd_en    = 1'b0;
    rd_addr  = phys(base, emit_idx);
    issue    = 1'b0;
    issue_nl = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_char != tlf_pkg::CH_NL) begin
          wr_en = 1'b1;
          if (in_char == tlf_pkg::CH_TAB) begin
            wr_data = tlf_pkg::CH_BLANK;
          end
        end
      end
      S_TAB: begin
        if (fill != W_C && !STOP_MAP[fill]) begin
          wr_en   = 1'b1;
          wr_data = tlf_pkg::CH_BLANK;
        end
      end
      S_EMIT: begin
        if (can_issue) begin
          issue = 1'b1;
          if (emit_idx < emit_len) begin
            rd_en = 1'b1;
          end else begin
            issue_nl = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      base       <= '0;
      last_blank <= '0;
      tok_valid  <= 1'b0;
      tok_nl     <= 1'b0;
    end else begin
      tok_valid <= issue;
      tok_nl    <= issue_nl;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_char == tlf_pkg::CH_NL) begin
              emit_len   <= fill;
              emit_rest  <= '0;
              emit_idx   <= '0;
              last_blank <= '0;
              state      <= S_EMIT;
            end else if (in_char == tlf_pkg::CH_TAB) begin
              if (fill != '0) begin
                last_blank <= fill;
              end
              fill  <= fill + 1'b1;
              state <= S_TAB;
            end else if (fill == W_C - 1'b1) begin
              if (lbx == '0) begin
                emit_len  <= W_C;
                emit_rest <= '0;
              end else begin
                emit_len  <= lbx + 1'b1;
                emit_rest <= W_C - (lbx + 1'b1);
              end
              emit_idx   <= '0;
              last_blank <= '0;
              state      <= S_EMIT;
            end else begin
              if (char_blank) begin
                last_blank <= fill;
              end
              fill <= fill + 1'b1;
            end
          end
        end
        S_TAB: begin
          if (fill == W_C) begin
            emit_len   <= W_C;
            emit_rest  <= '0;
            emit_idx   <= '0;
            last_blank <= '0;
            state      <= S_EMIT;
          end else if (STOP_MAP[fill]) begin
            state <= S_IDLE;
          end else begin
            last_blank <= fill;
            fill       <= fill + 1'b1;
          end
        end
        S_EMIT: begin
          if (can_issue) begin
            if (emit_idx < emit_len) begin
              emit_idx <= emit_idx + 1'b1;
            end else begin
              fill  <= emit_rest;
              base  <= phys(base, emit_len);
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tlf_line_ram #(
    .DEPTH(LINE_WIDTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign push_entry.ch   = tok_nl ? tlf_pkg::CH_NL : rd_data;
  assign push_entry.last = tok_nl;

  tlf_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_valid),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .cnt       (fifo_cnt)
  );

  assign out_valid = (fifo_cnt != 2'd0);
  assign out_char  = head.ch;
  assign last      = head.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (fifo_cnt < 2'd2 || pop))
    else $error("output queue overflow");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (fill < W_C))
    else $error("fill count reached line width while idle");

  a_blank_below_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (last_blank == '0 || last_blank < fill))
    else $error("break point beyond buffered text");

  a_nl_emits: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_char == tlf_pkg::CH_NL) |=> (state == S_EMIT))
    else $error("newline did not start a line flush");

endmodule

// ===== src/tlf_line_ram.sv =====
// Line buffer memory: one write port, one registered read port.
module tlf_line_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tlf_out_fifo.sv =====
// Two-entry output queue that parts the emit pipeline from the output channel.
module tlf_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tlf_pkg::out_entry_t push_entry,
  input  logic                pop,
  output tlf_pkg::out_entry_t head,
  output logic [1:0]          cnt
);

  tlf_pkg::out_entry_t ent0;
  tlf_pkg::out_entry_t ent1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            ent0 <= push_entry;
          end else begin
            ent1 <= push_entry;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          ent0 <= ent1;
          cnt  <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            ent0 <= push_entry;
          end else begin
            ent0 <= ent1;
            ent1 <= push_entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign head = ent0;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the text line folder: directed table, random text, flow control.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW = 32;
  localparam int TS = 8;
  localparam int RAND_ITEMS = 140;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 3 * LW;

  typedef enum logic [1:0] {BY_MODEL, NO_OUTPUT, ONE_NEWLINE} exp_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic [2:0] {SEQ_PROSE, SEQ_LONG_RUN, SEQ_LEAD_BLANK, SEQ_TABS, SEQ_NOISE}
    seq_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    exp_kind_t  kind;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       last;

  logic [7:0] line_buf [0:LW-1];
  int         fill_cnt = 0;
  tlf_pkg::out_entry_t folded_chars_q [$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         errors = 0;
  int         cycle_cnt = 0;
  int         rand_count = 0;

  stim_row_t directed [20] = '{
    '{tlf_pkg::CH_NL,    ONE_NEWLINE},
    '{8'h00,             NO_OUTPUT},
    '{8'hFF,             NO_OUTPUT},
    '{8'h80,             NO_OUTPUT},
    '{8'h7F,             NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{tlf_pkg::CH_NL,    BY_MODEL},
    '{tlf_pkg::CH_NL,    ONE_NEWLINE},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   BY_MODEL},
    '{8'h61,             NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   NO_OUTPUT},
    '{8'h62,             NO_OUTPUT},
    '{tlf_pkg::CH_TAB,   BY_MODEL},
    '{tlf_pkg::CH_BLANK, NO_OUTPUT},
    '{tlf_pkg::CH_NL,    BY_MODEL}
  };

  text_line_folder_core #(
    .LINE_WIDTH(LW),
    .TAB_STOP  (TS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .last     (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_stall <= ($urandom_range(0, 99) < 64);
      IDLE_BOTH: out_stall <= ($urandom_range(0, 99) < 38);
      default:   out_stall <= 1'b0;
    endcase
  end

  // sample between edges, where inputs and outputs are settled
  always @(negedge clk) begin
    tlf_pkg::out_entry_t want;
    if (!rst && out_valid && !out_stall) begin
      if (folded_chars_q.size() == 0) begin
        $error("unexpected transaction: out_char %h last %b", out_char, last);
        errors++;
      end else begin
        want = folded_chars_q.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char mismatch: expected %h, actual %h", want.ch, out_char);
          errors++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %b, actual %b", want.last, last);
          errors++;
        end
      end
    end
  end

  task automatic emit_line(input int len, ref tlf_pkg::out_entry_t res[$]);
    for (int i = 0; i < len; i++) res.push_back('{ch: line_buf[i], last: 1'b0});
    res.push_back('{ch: tlf_pkg::CH_NL, last: 1'b0});
  endtask

  task automatic fold_char(input logic [7:0] c, ref tlf_pkg::out_entry_t res[$]);
    int pos;
    int p;
    int brk;
    pos = fill_cnt;
    if (c == tlf_pkg::CH_TAB) begin
      do begin
        line_buf[pos] = tlf_pkg::CH_BLANK;
        pos++;
      end while (pos < LW && pos % TS != 0);
      if (pos >= LW) begin
        emit_line(pos, res);
        pos = 0;
      end
    end else if (c == tlf_pkg::CH_NL) begin
      emit_line(pos, res);
      pos = 0;
    end else begin
      line_buf[pos] = c;
      pos++;
      if (pos >= LW) begin
        p = LW - 1;
        while (p > 0 && line_buf[p] != tlf_pkg::CH_BLANK) p--;
        brk = (p == 0) ? LW : p + 1;
        emit_line(brk, res);
        pos = 0;
        for (int i = brk; i < LW; i++) begin
          line_buf[pos] = line_buf[i];
          pos++;
        end
      end
    end
    fill_cnt = pos;
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_char(input logic [7:0] c, input exp_kind_t kind);
    int                  gap_pct;
    bit                  took;
    tlf_pkg::out_entry_t res [$];
    gap_pct = (idle_mode == IDLE_SEND) ? 64 : (idle_mode == IDLE_BOTH) ? 38 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    fold_char(c, res);
    case (kind)
      NO_OUTPUT:   ;
      ONE_NEWLINE: folded_chars_q.push_back('{ch: tlf_pkg::CH_NL, last: 1'b1});
      default:     foreach (res[i]) folded_chars_q.push_back(res[i]);
    endcase
  endtask

  task automatic feed(input logic [7:0] c);
    if (rand_count < RAND_ITEMS) begin
      send_char(c, BY_MODEL);
      rand_count++;
    end
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == tlf_pkg::CH_TAB || c == tlf_pkg::CH_NL || c == tlf_pkg::CH_BLANK);
    return c;
  endfunction

  initial begin
    int        seq_n;
    int        n;
    int        r;
    seq_kind_t kind;
    seq_n = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_char(directed[i].ch, directed[i].kind);

    while (rand_count < RAND_ITEMS) begin
      idle_mode = idle_mode_t'(rand_count * 4 / RAND_ITEMS);
      if (seq_n < 5) begin
        kind = seq_kind_t'(seq_n);
      end else begin
        r = $urandom_range(0, 9);
        kind = (r < 5) ? SEQ_PROSE : (r == 5) ? SEQ_LONG_RUN : (r == 6) ? SEQ_LEAD_BLANK :
               (r == 7) ? SEQ_TABS : SEQ_NOISE;
      end
      case (kind)
        SEQ_PROSE: begin
          n = $urandom_range(3, 12);
          for (int w = 0; w < n; w++) begin
            repeat ($urandom_range(1, 12)) feed(8'($urandom_range(33, 126)));
            r = $urandom_range(0, 9);
            if (r < 7) feed(tlf_pkg::CH_BLANK);
            else if (r == 7) feed(tlf_pkg::CH_TAB);
            else if (r == 8) begin
              feed(tlf_pkg::CH_BLANK);
              feed(tlf_pkg::CH_BLANK);
            end
          end
          if ($urandom_range(0, 3) != 0) feed(tlf_pkg::CH_NL);
        end
        SEQ_LONG_RUN: begin
          repeat ($urandom_range(32, 70)) feed(plain_char());
        end
        SEQ_LEAD_BLANK: begin
          feed(tlf_pkg::CH_NL);
          feed(tlf_pkg::CH_BLANK);
          repeat ($urandom_range(31, 40)) feed(plain_char());
        end
        SEQ_TABS: begin
          repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 1) == 0) feed(tlf_pkg::CH_TAB);
            else feed(8'($urandom_range(33, 126)));
          end
          if ($urandom_range(0, 1) == 0) feed(tlf_pkg::CH_NL);
        end
        default: begin
          repeat ($urandom_range(5, 20)) begin
            r = $urandom_range(0, 9);
            if (r == 0) feed(tlf_pkg::CH_TAB);
            else if (r == 1) feed(tlf_pkg::CH_NL);
            else if (r == 2) feed(tlf_pkg::CH_BLANK);
            else feed(8'($urandom_range(0, 255)));
          end
        end
      endcase
      seq_n++;
    end

    in_valid <= 1'b0;
    while (folded_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
